// ===== rtl/core/esct_pkg.sv =====
// ----------------------------------------------------------------------------
// esct_pkg
// Shared types and constants of the engine speed and crank tracker.
// ----------------------------------------------------------------------------
package esct_pkg;

   // field widths
   localparam int PERIOD_W = 32;
   localparam int TEETH_W  = 10;
   localparam int AVGLEN_W = 7;
   localparam int Q88_W    = 16;
   localparam int SPEED_W  = 24;
   localparam int ANGLE_W  = 24;
   localparam int TOOTH_W  = 16;
   localparam int CMD_W    = 2;

   // divider widths: dividend holds the speed numerator, divisor period * teeth
   localparam int DVD_W = 39;
   localparam int DSR_W = PERIOD_W + TEETH_W;
   localparam int QCNT_W = 6;

   // 1.2e9 rpm counts scaled to Q.8
   localparam logic [DVD_W-1:0]   SPEED_NUM = 39'd307_200_000_000;
   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX = '1;
   localparam logic [TOOTH_W-1:0] TOOTH_MAX = '1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_AVG_LEN         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PICKUP_TEETH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_PER_TOOTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TDC_OFFSET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_TRACK_EN  = 3'd4;

   // event codes
   localparam logic [CMD_W-1:0] CMD_TOOTH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TDC   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PHASE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SPEED_START,
      ST_SPEED_WAIT,
      ST_RING,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_EMIT
   } esct_state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/esct_ram.sv =====
// ----------------------------------------------------------------------------
// esct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module esct_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/esct_div.sv =====
// ----------------------------------------------------------------------------
// esct_div
// Restoring divider, one quotient bit per cycle, shared by the speed and
// mean computations.
// ----------------------------------------------------------------------------
module esct_div (
   input  logic                 clock,
   input  logic                 reset,
   input  esct_pkg::div_req_type req,
   output esct_pkg::div_rsp_type rsp
);
   import esct_pkg::*;

   logic [DSR_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DSR_W-1:0]  dsr_ff, dsr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DSR_W:0]    rem_sh;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = ge ? DSR_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DSR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + QCNT_W'(1);
         if (cnt_ff == QCNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/engine_speed_crank_tracker.sv =====
// ----------------------------------------------------------------------------
// engine_speed_crank_tracker
// Flywheel speed, moving-average speed and crank angle from tooth, TDC and
// phase events.
// ----------------------------------------------------------------------------
// A tooth beat runs from acceptance to result through the speed quotient
// and the ring mean, each one pass through the shared restoring divider,
// plus the multiply, the ring read and write-back and the result register.
// A zero period * teeth skips the speed pass, and before the ring has filled
// the mean pass is skipped. TDC, phase and unused codes go to the result
// without the divider. One beat is worked on at a time; a new beat is taken
// while the previous result still waits on rsp_stall. Speed samples live in
// a MAX_AVG entry RAM; writing avg_len restarts the average.
module engine_speed_crank_tracker #(
   parameter int MAX_AVG = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [esct_pkg::CMD_W-1:0]            req_command,
   input  logic [esct_pkg::PERIOD_W-1:0]         req_period,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [esct_pkg::SPEED_W-1:0]          rsp_speed_avg,
   output logic [esct_pkg::SPEED_W-1:0]          rsp_speed_raw,
   output logic                                  rsp_average_valid,
   output logic [esct_pkg::ANGLE_W-1:0]          rsp_shaft_angle,
   output logic [esct_pkg::TOOTH_W-1:0]          rsp_tooth_index,
   output logic                                  rsp_div_error,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [esct_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [esct_pkg::CSR_DATA_W-1:0]       csr_data
);
   import esct_pkg::*;

   localparam int AW    = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
   localparam int LEN_W = $clog2(MAX_AVG + 1);
   localparam int CW    = (LEN_W > AVGLEN_W) ? LEN_W : AVGLEN_W;
   localparam int SUM_W = SPEED_W + LEN_W;

   // configuration registers
   logic [AVGLEN_W-1:0] avg_len_ff, avg_len_in;
   logic [TEETH_W-1:0]  teeth_cfg_ff, teeth_cfg_in;
   logic [Q88_W-1:0]    apt_ff, apt_in;
   logic [Q88_W-1:0]    tdc_off_ff, tdc_off_in;
   logic                track_en_ff, track_en_in;

   // control and tracking state
   esct_state_type      state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [AW-1:0]       wpos_ff, wpos_in;
   logic                filled_ff, filled_in;
   logic [ANGLE_W-1:0]  angle_ff, angle_in;
   logic [TOOTH_W-1:0]  teeth_ff, teeth_in;
   logic                half_ff, half_in;
   logic                pending_ff, pending_in;
   logic [SPEED_W-1:0]  last_avg_ff, last_avg_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [DSR_W-1:0]    prod_ff, prod_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [SPEED_W-1:0]  old_ff, old_in;
   logic [SPEED_W-1:0]  raw_ff, raw_in;
   logic                err_ff, err_in;

   // result registers
   logic [SPEED_W-1:0]  out_avg_ff, out_avg_in;
   logic [SPEED_W-1:0]  out_raw_ff, out_raw_in;
   logic                out_filled_ff, out_filled_in;
   logic [ANGLE_W-1:0]  out_angle_ff, out_angle_in;
   logic [TOOTH_W-1:0]  out_teeth_ff, out_teeth_in;
   logic                out_err_ff, out_err_in;

   // combinational helpers
   logic [CW-1:0]       avg_ext;
   logic [LEN_W-1:0]    len_eff;
   logic [AW-1:0]       pos_cur;
   logic [LEN_W:0]      pos_inc;
   logic [ANGLE_W:0]    angle_sum;
   logic [Q88_W-1:0]    angle_add;
   logic                req_accept;
   logic                rsp_free;

   logic                ram_wr_en;
   logic [SPEED_W-1:0]  ram_rd_data;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   esct_ram #(
      .WIDTH (SPEED_W),
      .DEPTH (MAX_AVG)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (raw_ff),
      .rd_addr (pos_cur),
      .rd_data (ram_rd_data)
   );

   esct_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // ring length clamped to 1..MAX_AVG, the slot this tooth lands in and the next angle
   always_comb begin
      avg_ext = CW'(avg_len_ff);
      if (avg_ext == '0) begin
         len_eff = LEN_W'(1);
      end else if (avg_ext > CW'(MAX_AVG)) begin
         len_eff = LEN_W'(MAX_AVG);
      end else begin
         len_eff = LEN_W'(avg_ext);
      end
      pos_cur = (LEN_W'(wpos_ff) < len_eff) ? wpos_ff : '0;
      pos_inc = {1'b0, LEN_W'(pos_ff)} + (LEN_W + 1)'(1);
      angle_add = pending_ff ? tdc_off_ff : apt_ff;
      angle_sum = {1'b0, angle_ff} + (ANGLE_W + 1)'(angle_add);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (cmd_ff == CMD_TOOTH) ? ST_SPEED_START : ST_EMIT;
         end
         ST_SPEED_START: begin
            state_in = (prod_ff == '0) ? ST_RING : ST_SPEED_WAIT;
         end
         ST_SPEED_WAIT: begin
            if (div_rsp.done) state_in = ST_RING;
         end
         ST_RING: begin
            state_in = ST_MEAN_START;
         end
         ST_MEAN_START: begin
            state_in = filled_ff ? ST_MEAN_WAIT : ST_EMIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      avg_len_in    = avg_len_ff;
      teeth_cfg_in  = teeth_cfg_ff;
      apt_in        = apt_ff;
      tdc_off_in    = tdc_off_ff;
      track_en_in   = track_en_ff;
      sum_in        = sum_ff;
      wpos_in       = wpos_ff;
      filled_in     = filled_ff;
      angle_in      = angle_ff;
      teeth_in      = teeth_ff;
      half_in       = half_ff;
      pending_in    = pending_ff;
      last_avg_in   = last_avg_ff;
      cmd_in        = cmd_ff;
      period_in     = period_ff;
      prod_in       = prod_ff;
      pos_in        = pos_ff;
      old_in        = old_ff;
      raw_in        = raw_ff;
      err_in        = err_ff;
      out_avg_in    = out_avg_ff;
      out_raw_in    = out_raw_ff;
      out_filled_in = out_filled_ff;
      out_angle_in  = out_angle_ff;
      out_teeth_in  = out_teeth_ff;
      out_err_in    = out_err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_wr_en     = 1'b0;
      div_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in    = req_command;
               period_in = req_period;
            end
         end
         ST_EXEC: begin
            raw_in = '0;
            err_in = 1'b0;
            case (cmd_ff)
               CMD_TOOTH: begin
                  prod_in  = DSR_W'(period_ff) * DSR_W'(teeth_cfg_ff);
                  pos_in   = pos_cur;
                  teeth_in = (teeth_ff == TOOTH_MAX) ? teeth_ff : teeth_ff + TOOTH_W'(1);
                  if (track_en_ff) begin
                     pending_in = 1'b0;
                     angle_in   = angle_sum[ANGLE_W] ? ANGLE_MAX : angle_sum[ANGLE_W-1:0];
                  end
               end
               CMD_TDC: begin
                  // every second TDC clears the angle and the tooth count and arms the offset
                  if (half_ff) begin
                     half_in    = 1'b0;
                     angle_in   = '0;
                     teeth_in   = '0;
                     pending_in = 1'b1;
                  end else begin
                     half_in = 1'b1;
                  end
               end
               CMD_PHASE: begin
                  pending_in = 1'b1;
               end
               default: ;
            endcase
         end
         ST_SPEED_START: begin
            old_in = ram_rd_data;
            if (prod_ff == '0) begin
               raw_in = SPEED_MAX;
               err_in = 1'b1;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = SPEED_NUM;
               div_req.divisor  = prod_ff;
            end
         end
         ST_SPEED_WAIT: begin
            if (div_rsp.done) begin
               raw_in = (div_rsp.quotient > DVD_W'(SPEED_MAX)) ? SPEED_MAX
                                                               : div_rsp.quotient[SPEED_W-1:0];
            end
         end
         ST_RING: begin
            // retire the overwritten sample once the ring is full
            ram_wr_en = 1'b1;
            sum_in = sum_ff - (filled_ff ? SUM_W'(old_ff) : '0) + SUM_W'(raw_ff);
            if (pos_inc >= {1'b0, len_eff}) begin
               wpos_in   = '0;
               filled_in = 1'b1;
            end else begin
               wpos_in = pos_inc[AW-1:0];
            end
         end
         ST_MEAN_START: begin
            if (filled_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'(sum_ff);
               div_req.divisor  = DSR_W'(len_eff);
            end else begin
               last_avg_in = raw_ff;
            end
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) last_avg_in = div_rsp.quotient[SPEED_W-1:0];
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               out_avg_in    = last_avg_ff;
               out_raw_in    = raw_ff;
               out_filled_in = filled_ff;
               out_angle_in  = angle_ff;
               out_teeth_in  = teeth_ff;
               out_err_in    = err_ff;
            end
         end
         default: ;
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AVG_LEN: begin
               avg_len_in = csr_data[AVGLEN_W-1:0];
               wpos_in    = '0;
               filled_in  = 1'b0;
               sum_in     = '0;
            end
            CSR_PICKUP_TEETH:    teeth_cfg_in = csr_data[TEETH_W-1:0];
            CSR_ANGLE_PER_TOOTH: apt_in       = csr_data;
            CSR_TDC_OFFSET:      tdc_off_in   = csr_data;
            CSR_ANGLE_TRACK_EN:  track_en_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         avg_len_ff   <= AVGLEN_W'(30);
         teeth_cfg_ff <= TEETH_W'(1);
         apt_ff       <= Q88_W'(307);
         tdc_off_ff   <= '0;
         track_en_ff  <= 1'b1;
         sum_ff       <= '0;
         wpos_ff      <= '0;
         filled_ff    <= 1'b0;
         angle_ff     <= '0;
         teeth_ff     <= '0;
         half_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         last_avg_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_len_ff   <= avg_len_in;
         teeth_cfg_ff <= teeth_cfg_in;
         apt_ff       <= apt_in;
         tdc_off_ff   <= tdc_off_in;
         track_en_ff  <= track_en_in;
         sum_ff       <= sum_in;
         wpos_ff      <= wpos_in;
         filled_ff    <= filled_in;
         angle_ff     <= angle_in;
         teeth_ff     <= teeth_in;
         half_ff      <= half_in;
         pending_ff   <= pending_in;
         last_avg_ff  <= last_avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      period_ff     <= period_in;
      prod_ff       <= prod_in;
      pos_ff        <= pos_in;
      old_ff        <= old_in;
      raw_ff        <= raw_in;
      err_ff        <= err_in;
      out_avg_ff    <= out_avg_in;
      out_raw_ff    <= out_raw_in;
      out_filled_ff <= out_filled_in;
      out_angle_ff  <= out_angle_in;
      out_teeth_ff  <= out_teeth_in;
      out_err_ff    <= out_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_avg     = out_avg_ff;
   assign rsp_speed_raw     = out_raw_ff;
   assign rsp_average_valid = out_filled_ff;
   assign rsp_shaft_angle   = out_angle_ff;
   assign rsp_tooth_index   = out_teeth_ff;
   assign rsp_div_error     = out_err_ff;

endmodule

// ===== verif/esct_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esct_checker
// Watches the event, result and register channels of the tracker, predicts
// each speed and crank reading, and compares it field by field.
// ----------------------------------------------------------------------------
module esct_checker #(
   parameter int MAX_AVG = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [esct_pkg::CMD_W-1:0]      req_command,
   input  logic [esct_pkg::PERIOD_W-1:0]   req_period,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [esct_pkg::SPEED_W-1:0]    rsp_speed_avg,
   input  logic [esct_pkg::SPEED_W-1:0]    rsp_speed_raw,
   input  logic                            rsp_average_valid,
   input  logic [esct_pkg::ANGLE_W-1:0]    rsp_shaft_angle,
   input  logic [esct_pkg::TOOTH_W-1:0]    rsp_tooth_index,
   input  logic                            rsp_div_error,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [esct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [esct_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              fail_count,
   output int                              pending
);
   import esct_pkg::*;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_avg;
      logic [SPEED_W-1:0] speed_raw;
      logic               average_valid;
      logic [ANGLE_W-1:0] shaft_angle;
      logic [TOOTH_W-1:0] tooth_index;
      logic               div_error;
   } reading_type;

   reading_type due_readings[$];

   // register copies
   logic [AVGLEN_W-1:0] avg_len_q;
   logic [TEETH_W-1:0]  teeth_q;
   logic [Q88_W-1:0]    angle_step_q;
   logic [Q88_W-1:0]    tdc_offset_q;
   logic                track_en_q;

   // tracker state
   logic [SPEED_W-1:0]  speed_ring [0:MAX_AVG-1];
   logic [31:0]         ring_sum;
   int                  write_pos;
   logic                ring_full;
   logic [ANGLE_W-1:0]  angle_now;
   logic [TOOTH_W-1:0]  teeth_seen;
   logic                second_tdc;
   logic                offset_armed;
   logic [SPEED_W-1:0]  last_avg_out;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   function automatic reading_type predict_reading(input logic [CMD_W-1:0] cmd,
                                                   input logic [PERIOD_W-1:0] per);
      reading_type r;
      logic [63:0] divisor;
      logic [63:0] quot;
      logic [ANGLE_W:0] angle_next;
      logic [Q88_W-1:0] angle_add;
      int len;
      int pos;
      r.speed_avg = last_avg_out;
      r.speed_raw = '0;
      r.div_error = 1'b0;
      case (cmd)
         CMD_TOOTH: begin
            divisor = 64'(per) * 64'(teeth_q);
            if (divisor == 64'd0) begin
               r.speed_raw = SPEED_MAX;
               r.div_error = 1'b1;
            end else begin
               quot = 64'(SPEED_NUM) / divisor;
               r.speed_raw = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
            end
            // clamp the ring length into 1..MAX_AVG
            if (avg_len_q == '0)
               len = 1;
            else if (int'(avg_len_q) > MAX_AVG)
               len = MAX_AVG;
            else
               len = int'(avg_len_q);
            pos = (write_pos < len) ? write_pos : 0;
            if (ring_full)
               ring_sum -= 32'(speed_ring[pos]);
            speed_ring[pos] = r.speed_raw;
            ring_sum += 32'(r.speed_raw);
            if (pos + 1 >= len) begin
               write_pos = 0;
               ring_full = 1'b1;
            end else begin
               write_pos = pos + 1;
            end
            r.speed_avg = ring_full ? SPEED_W'(ring_sum / 32'(len)) : r.speed_raw;
            last_avg_out = r.speed_avg;
            if (teeth_seen != TOOTH_MAX)
               teeth_seen++;
            if (track_en_q) begin
               // an armed correction replaces one tooth step
               if (offset_armed) begin
                  angle_add = tdc_offset_q;
                  offset_armed = 1'b0;
               end else begin
                  angle_add = angle_step_q;
               end
               angle_next = {1'b0, angle_now} + (ANGLE_W+1)'(angle_add);
               angle_now = (angle_next > (ANGLE_W+1)'(ANGLE_MAX)) ?
                           ANGLE_MAX : angle_next[ANGLE_W-1:0];
            end
         end
         CMD_TDC: begin
            if (second_tdc) begin
               second_tdc = 1'b0;
               angle_now = '0;
               teeth_seen = '0;
               offset_armed = 1'b1;
            end else begin
               second_tdc = 1'b1;
            end
         end
         CMD_PHASE: offset_armed = 1'b1;
         default: ;
      endcase
      r.average_valid = ring_full;
      r.shaft_angle = angle_now;
      r.tooth_index = teeth_seen;
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         avg_len_q = AVGLEN_W'(30);
         teeth_q = TEETH_W'(1);
         angle_step_q = Q88_W'(307);
         tdc_offset_q = '0;
         track_en_q = 1'b1;
         ring_sum = '0;
         write_pos = 0;
         ring_full = 1'b0;
         angle_now = '0;
         teeth_seen = '0;
         second_tdc = 1'b0;
         offset_armed = 1'b0;
         last_avg_out = '0;
         due_readings.delete();
      end else begin
         // retire first so a beat taken on this edge never matches itself
         if (rsp_valid && !rsp_stall) begin
            if (due_readings.size() == 0) begin
               report_mismatch("result beat with no reading due");
            end else begin
               want = due_readings.pop_front();
               check_field("speed_avg", 32'(rsp_speed_avg), 32'(want.speed_avg));
               check_field("speed_raw", 32'(rsp_speed_raw), 32'(want.speed_raw));
               check_field("average_valid", 32'(rsp_average_valid),
                           32'(want.average_valid));
               check_field("shaft_angle", 32'(rsp_shaft_angle), 32'(want.shaft_angle));
               check_field("tooth_index", 32'(rsp_tooth_index), 32'(want.tooth_index));
               check_field("div_error", 32'(rsp_div_error), 32'(want.div_error));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AVG_LEN: begin
                  avg_len_q = csr_data[AVGLEN_W-1:0];
                  write_pos = 0;
                  ring_full = 1'b0;
                  ring_sum = '0;
               end
               CSR_PICKUP_TEETH:    teeth_q = csr_data[TEETH_W-1:0];
               CSR_ANGLE_PER_TOOTH: angle_step_q = csr_data[Q88_W-1:0];
               CSR_TDC_OFFSET:      tdc_offset_q = csr_data[Q88_W-1:0];
               CSR_ANGLE_TRACK_EN:  track_en_q = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            due_readings.push_back(predict_reading(req_command, req_period));
      end
      pending <= due_readings.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds tooth, TDC and phase events and register writes to the speed and
// crank tracker, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
   import esct_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int N_PHASES    = 10;
   localparam int PHASE_BEATS = 200;
   localparam int CLIMB_BEATS = 300;

   bit                    clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command;
   logic [PERIOD_W-1:0]   req_period;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SPEED_W-1:0]    rsp_speed_avg;
   logic [SPEED_W-1:0]    rsp_speed_raw;
   logic                  rsp_average_valid;
   logic [ANGLE_W-1:0]    rsp_shaft_angle;
   logic [TOOTH_W-1:0]    rsp_tooth_index;
   logic                  rsp_div_error;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;
   bit                    quiet;

   engine_speed_crank_tracker #(.MAX_AVG(64)) dut (.*);

   esct_checker #(.MAX_AVG(64)) u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #30_000_000;
      $display("simulation failed");
      $finish;
   end

   // result side: random stall bursts
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst == 0 && !quiet && $urandom_range(0, 9) == 0)
            burst = $urandom_range(1, 18);
         if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic sender_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [PERIOD_W-1:0] per);
      if (!quiet && $urandom_range(0, 5) == 0)
         sender_gap($urandom_range(1, 18));
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_period <= per;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_all_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly a steady engine with jitter, sometimes anything from 0 up
   function automatic logic [PERIOD_W-1:0] tooth_period(input logic [PERIOD_W-1:0] base);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll == 0)
         return '0;
      else if (roll < 70)
         return base + PERIOD_W'($urandom_range(0, int'(base >> 3)));
      else
         return PERIOD_W'($urandom) >> $urandom_range(0, 31);
   endfunction

   initial begin
      int rev_left;
      int roll;
      int beats;
      bit climb;
      logic [PERIOD_W-1:0] base;

      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TOOTH;
      req_period = '0;
      csr_valid = 1'b0;
      csr_index = CSR_AVG_LEN;
      csr_data = '0;
      quiet = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero period, speed extremes, TDC pair, phase, unused code
      send_event(CMD_TOOTH, '0);
      send_event(CMD_TOOTH, '1);
      send_event(CMD_TOOTH, 32'd1);
      send_event(CMD_TOOTH, 32'd18310);
      send_event(CMD_TOOTH, 32'd18311);
      send_event(CMD_TDC, 32'd0);
      send_event(CMD_TDC, 32'd0);
      send_event(CMD_PHASE, 32'd0);
      send_event(CMD_TOOTH, 32'd600000);
      send_event(CMD_UNUSED, PERIOD_W'($urandom));

      // zero teeth, zero length ring, tracking off with a correction armed
      wait_all_results();
      write_register(CSR_AVG_LEN, 16'd0);
      write_register(CSR_PICKUP_TEETH, 16'd0);
      write_register(CSR_ANGLE_PER_TOOTH, 16'hFFFF);
      write_register(CSR_TDC_OFFSET, 16'hFFFF);
      write_register(CSR_ANGLE_TRACK_EN, 16'd0);
      send_event(CMD_TOOTH, 32'd12345);
      send_event(CMD_PHASE, 32'd0);
      send_event(CMD_TOOTH, 32'd5);

      // oversize ring length, max teeth, tracking back on
      wait_all_results();
      write_register(CSR_AVG_LEN, 16'd127);
      write_register(CSR_PICKUP_TEETH, 16'd1023);
      write_register(CSR_ANGLE_TRACK_EN, 16'd1);
      send_event(CMD_TOOTH, 32'd100);
      send_event(CMD_TOOTH, 32'd200);
      send_event(CMD_TDC, 32'd0);
      send_event(CMD_TDC, 32'd0);
      send_event(CMD_TOOTH, 32'd3000);

      for (int p = 0; p < N_PHASES; p++) begin
         // one phase runs without TDC at the largest step to pin the angle
         climb = (p == 3);
         wait_all_results();
         quiet = (p == N_PHASES - 1) || ($urandom_range(0, 3) == 0);
         case (p)
            0:       write_register(CSR_AVG_LEN, 16'd64);
            1:       write_register(CSR_AVG_LEN, 16'd1);
            2:       write_register(CSR_AVG_LEN, 16'd0);
            4:       write_register(CSR_AVG_LEN, 16'd127);
            default: write_register(CSR_AVG_LEN, 16'($urandom_range(1, 64)));
         endcase
         case (p)
            6:       write_register(CSR_PICKUP_TEETH, 16'd0);
            7:       write_register(CSR_PICKUP_TEETH, 16'd1023);
            default: write_register(CSR_PICKUP_TEETH, 16'($urandom_range(1, 1023)));
         endcase
         if (climb)
            write_register(CSR_ANGLE_PER_TOOTH, 16'hFFFF);
         else if (p == 0)
            write_register(CSR_ANGLE_PER_TOOTH, 16'd0);
         else
            write_register(CSR_ANGLE_PER_TOOTH, 16'($urandom));
         if (p == 0)
            write_register(CSR_TDC_OFFSET, 16'd0);
         else if (p == 1)
            write_register(CSR_TDC_OFFSET, 16'hFFFF);
         else
            write_register(CSR_TDC_OFFSET, 16'($urandom));
         if (climb)
            write_register(CSR_ANGLE_TRACK_EN, 16'd1);
         else if (p == 8)
            write_register(CSR_ANGLE_TRACK_EN, 16'd0);
         else
            write_register(CSR_ANGLE_TRACK_EN, 16'($urandom_range(0, 3) != 0));
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_UNUSED, 16'($urandom));

         base = PERIOD_W'($urandom) >> $urandom_range(4, 26);
         rev_left = $urandom_range(1, 40);
         beats = climb ? CLIMB_BEATS : PHASE_BEATS;
         for (int i = 0; i < beats; i++) begin
            roll = $urandom_range(0, 99);
            if (climb || (roll < 85 && rev_left > 0)) begin
               send_event(CMD_TOOTH, tooth_period(base));
               rev_left--;
            end else if (roll < 85) begin
               send_event(CMD_TDC, PERIOD_W'($urandom));
               rev_left = $urandom_range(1, 40);
            end else if (roll < 92) begin
               send_event(CMD_PHASE, PERIOD_W'($urandom));
            end else begin
               // noise: any code, any period
               send_event(CMD_W'($urandom_range(0, 3)), PERIOD_W'($urandom));
            end
         end
      end

      wait_all_results();
      repeat (200) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
